// ----- hw/rtl/linear_interp_resampler_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the linear interpolation resampler
// Shared property forms, clocked on clk and disabled during arst_n.
// ----------------------------------------------------------------------------
`ifndef LINEAR_INTERP_RESAMPLER_UNIT_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_UNIT_ASSERT_SVH

// same-cycle implication
`define LIRS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lirs: same-cycle check failed");

// next-cycle implication
`define LIRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lirs: next-cycle check failed");

`endif

// ----- hw/rtl/lirs_pkg.sv -----
// ----------------------------------------------------------------------------
// lirs_pkg
// Types and constants shared by the resampler front, queue and back.
// ----------------------------------------------------------------------------
package lirs_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 16;
	localparam int RATIO_BITS  = 24;
	localparam int POS_BITS    = 25;

	localparam logic [RATIO_BITS-1:0] RATIO_RESET = RATIO_BITS'(1) << FRAC_BITS;
	localparam logic [RATIO_BITS-1:0] MIN_RATIO   = RATIO_BITS'(1) << (FRAC_BITS - 4);

	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

	// what the back has to do for one input sample
	typedef enum logic [1:0] {
		KIND_PRIME,     // first sample of a stream, nothing to emit
		KIND_SPAN,      // interpolate over the interval ending here
		KIND_SPAN_END,  // interpolate, then hold the final sample
		KIND_SOLO       // first and final sample: hold only
	} kind_t;

	typedef struct packed {
		kind_t                          kind;
		logic signed [SAMPLE_BITS-1:0]  prev;
		logic signed [SAMPLE_BITS-1:0]  cur;
	} cmd_t;

endpackage

// ----- hw/rtl/linear_interp_resampler_unit.sv -----
// ----------------------------------------------------------------------------
// linear_interp_resampler_unit
// Streaming linear interpolation sample rate converter, Q1.15 samples.
//
// Input channel: in_valid/in_stall with in_sample and in_last. Each transfer
// is one source sample; in_last closes the stream and the state restarts.
// Output channel: out_valid/out_stall with out_sample, run_last (last output
// caused by one input) and stream_last (final output of the stream).
// Register: cfg_wr_en/cfg_wr_data load ratio_step, Q8.16 input positions per
// output, write only while idle. Values under 1/16 act as 1/16.
// The first output of an input passes the command queue, the walker's command
// register and the output register. Throughput: outputs of one input leave
// one per cycle while out_stall is low; an input occupies the position walker
// through its interpolation run, and through the hold run too when it closes a
// stream it did not open; the walker is the one shared interpolation datapath.
// A four-entry command queue lets inputs keep flowing while the walker runs.
// Out_stall holds the output register; the walker waits and the queue fills,
// raising in_stall when full. Reset clears the queue, state and ratio (1.0).
// ----------------------------------------------------------------------------
module linear_interp_resampler_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_wr_en,
	input  logic [lirs_pkg::RATIO_BITS-1:0]         cfg_wr_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [lirs_pkg::SAMPLE_BITS-1:0] in_sample,
	input  logic                                    in_last,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [lirs_pkg::SAMPLE_BITS-1:0] out_sample,
	output logic                                    run_last,
	output logic                                    stream_last
);
	import lirs_pkg::*;

	logic [RATIO_BITS-1:0] ratio_q;
	logic                  cmd_full;
	logic                  cmd_empty;
	logic                  cmd_push;
	logic                  cmd_pop;
	cmd_t                  cmd_wr;
	cmd_t                  cmd_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
		end else if (cfg_wr_en) begin
			ratio_q <= cfg_wr_data;
		end
	end

	lirs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_sample (in_sample),
		.in_last   (in_last),
		.cmd_full  (cmd_full),
		.cmd_push  (cmd_push),
		.cmd_wr    (cmd_wr)
	);

	lirs_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.wr_data (cmd_wr),
		.full    (cmd_full),
		.pop     (cmd_pop),
		.rd_data (cmd_rd),
		.empty   (cmd_empty)
	);

	lirs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.ratio       (ratio_q),
		.cmd_rd      (cmd_rd),
		.cmd_empty   (cmd_empty),
		.cmd_pop     (cmd_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_sample  (out_sample),
		.run_last    (run_last),
		.stream_last (stream_last)
	);

endmodule

// ----- hw/rtl/lirs_front.sv -----
// ----------------------------------------------------------------------------
// lirs_front
// Accepts input samples, tracks stream start and classifies each transfer.
// ----------------------------------------------------------------------------
module lirs_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [lirs_pkg::SAMPLE_BITS-1:0] in_sample,
	input  logic                                  in_last,
	input  logic                                  cmd_full,
	output logic                                  cmd_push,
	output lirs_pkg::cmd_t                        cmd_wr
);
	import lirs_pkg::*;

	logic signed [SAMPLE_BITS-1:0] prev_q;
	logic                          primed_q;

	assign in_stall = cmd_full;
	assign cmd_push = in_valid && !cmd_full;

	always_comb begin
		cmd_wr.prev = prev_q;
		cmd_wr.cur  = in_sample;
		if (primed_q) begin
			cmd_wr.kind = in_last ? KIND_SPAN_END : KIND_SPAN;
		end else begin
			cmd_wr.kind = in_last ? KIND_SOLO : KIND_PRIME;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			primed_q <= 1'b0;
		end else if (cmd_push) begin
			if (in_last) begin
				prev_q   <= '0;
				primed_q <= 1'b0;
			end else begin
				prev_q   <= in_sample;
				primed_q <= 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/lirs_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// lirs_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module lirs_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lirs_pkg::cmd_t wr_data,
	output logic           full,
	input  logic           pop,
	output lirs_pkg::cmd_t rd_data,
	output logic           empty
);
	import lirs_pkg::*;

	cmd_t                     entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [FIFO_PTR_BITS:0]   count_q;

	assign full    = (count_q == (FIFO_PTR_BITS+1)'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/lirs_back.sv -----
// ----------------------------------------------------------------------------
// lirs_back
// Walks output positions for one command and emits interpolated or held samples.
// ----------------------------------------------------------------------------
module lirs_back (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic [lirs_pkg::RATIO_BITS-1:0]         ratio,
	input  lirs_pkg::cmd_t                          cmd_rd,
	input  logic                                    cmd_empty,
	output logic                                    cmd_pop,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [lirs_pkg::SAMPLE_BITS-1:0] out_sample,
	output logic                                    run_last,
	output logic                                    stream_last
);
	import lirs_pkg::*;

	localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;
	localparam int Q_W    = SAMPLE_BITS + 2;
	localparam logic signed [PROD_W-1:0] ROUND = PROD_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [Q_W-1:0] SMAX = Q_W'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [Q_W-1:0] SMIN = -SMAX - Q_W'(1);
	localparam logic [POS_BITS-1:0] ONE_POS = POS_BITS'(1) << FRAC_BITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INTERP,
		ST_HOLD
	} state_t;

	state_t                        state_q;
	cmd_t                          cmd_q;
	logic [POS_BITS-1:0]           pos_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;
	logic                          run_last_q;
	logic                          stream_last_q;

	logic [POS_BITS-1:0]           step;
	logic [POS_BITS-1:0]           pos_nxt;
	logic                          in_span;
	logic                          next_out;
	logic                          next_in_tail;
	logic                          slot_free;
	logic                          final_emit;
	logic                          emit;

	logic signed [SAMPLE_BITS:0]   diff;
	logic signed [FRAC_BITS:0]     frac_s;
	logic signed [PROD_W-1:0]      prod;
	logic signed [Q_W-1:0]         q_frac;
	logic signed [Q_W-1:0]         q_sum;
	logic signed [SAMPLE_BITS-1:0] interp_val;

	assign step = (ratio < MIN_RATIO) ? POS_BITS'(MIN_RATIO) : POS_BITS'(ratio);
	assign pos_nxt      = pos_q + step;
	assign in_span      = (pos_q[POS_BITS-1:FRAC_BITS] == '0);
	assign next_out     = (pos_nxt[POS_BITS-1:FRAC_BITS] != '0);
	assign next_in_tail = (pos_nxt[POS_BITS-1:FRAC_BITS+1] == '0);
	assign slot_free    = !out_valid_q || !out_stall;
	assign cmd_pop      = (state_q == ST_IDLE) && !cmd_empty;
	assign emit         = slot_free && in_span &&
	                      ((state_q == ST_INTERP) || (state_q == ST_HOLD));

	always_comb begin
		if (state_q == ST_INTERP) begin
			final_emit = next_out && !((cmd_q.kind == KIND_SPAN_END) && next_in_tail);
		end else begin
			final_emit = next_out;
		end
	end

	always_comb begin
		diff   = {cmd_q.cur[SAMPLE_BITS-1], cmd_q.cur} - {cmd_q.prev[SAMPLE_BITS-1], cmd_q.prev};
		frac_s = {1'b0, pos_q[FRAC_BITS-1:0]};
		prod   = PROD_W'(diff) * PROD_W'(frac_s) + ROUND;
		q_frac = signed'(prod[FRAC_BITS +: Q_W]);
		q_sum  = q_frac + Q_W'(cmd_q.prev);
		if (q_sum > SMAX) begin
			interp_val = SAMPLE_BITS'(SMAX);
		end else if (q_sum < SMIN) begin
			interp_val = SAMPLE_BITS'(SMIN);
		end else begin
			interp_val = q_sum[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cmd_q         <= '0;
			pos_q         <= '0;
			out_valid_q   <= 1'b0;
			out_sample_q  <= '0;
			run_last_q    <= 1'b0;
			stream_last_q <= 1'b0;
		end else begin
			if (slot_free) begin
				out_valid_q <= emit;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						cmd_q <= cmd_rd;
						unique case (cmd_rd.kind)
							KIND_PRIME:    state_q <= ST_IDLE;
							KIND_SPAN:     state_q <= ST_INTERP;
							KIND_SPAN_END: state_q <= ST_INTERP;
							KIND_SOLO:     state_q <= ST_HOLD;
							default:       state_q <= ST_IDLE;
						endcase
					end
				end
				ST_INTERP: begin
					if (in_span) begin
						if (slot_free) begin
							out_sample_q  <= interp_val;
							run_last_q    <= final_emit;
							stream_last_q <= final_emit && (cmd_q.kind == KIND_SPAN_END);
							pos_q         <= pos_nxt;
						end
					end else begin
						pos_q   <= pos_q - ONE_POS;
						state_q <= (cmd_q.kind == KIND_SPAN_END) ? ST_HOLD : ST_IDLE;
					end
				end
				ST_HOLD: begin
					if (in_span) begin
						if (slot_free) begin
							out_sample_q  <= cmd_q.cur;
							run_last_q    <= final_emit;
							stream_last_q <= final_emit;
							pos_q         <= pos_nxt;
						end
					end else begin
						pos_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_sample  = out_sample_q;
	assign run_last    = run_last_q;
	assign stream_last = stream_last_q;

endmodule

// ----- hw/rtl/lirs_checker.sv -----
// ----------------------------------------------------------------------------
// lirs_checker
// Port-level checks on the resampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "linear_interp_resampler_unit_assert.svh"

module lirs_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    in_valid,
	input logic                                    in_stall,
	input logic signed [lirs_pkg::SAMPLE_BITS-1:0] in_sample,
	input logic                                    in_last,
	input logic                                    out_valid,
	input logic                                    out_stall,
	input logic signed [lirs_pkg::SAMPLE_BITS-1:0] out_sample,
	input logic                                    run_last,
	input logic                                    stream_last
);
	import lirs_pkg::*;

	logic [SAMPLE_BITS:0]   in_payload;
	logic [SAMPLE_BITS+1:0] out_payload;

	assign in_payload  = {in_sample, in_last};
	assign out_payload = {out_sample, run_last, stream_last};

	// stalled input transfer keeps valid and payload
	`LIRS_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_payload))

	// stalled output transfer keeps its payload
	`LIRS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_payload))

	// stream end always closes the run of its input
	`LIRS_ASSERT_NOW(a_stream_run, out_valid && stream_last, run_last)

	// first cycle out of reset: queue empty, nothing to show
	`LIRS_ASSERT_NOW(a_reset_clear, $past(arst_n) == 1'b0, !out_valid && !in_stall)

endmodule

bind linear_interp_resampler_unit lirs_checker u_lirs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.in_sample   (in_sample),
	.in_last     (in_last),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_sample  (out_sample),
	.run_last    (run_last),
	.stream_last (stream_last)
);

// ----- tb/sv/linear_interp_resampler_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_interp_resampler_unit_test
// Self-checking bench for the linear interpolation resampler. A built-in
// predictor tracks the previous sample, the next output position and the
// ratio register, and queues the outputs each input transfer must produce.
// Every output transfer is checked field by field against the oldest queued
// output. Directed streams cover sample extremes, the ratio floor, single
// sample streams and a final step with no output; random streams follow under
// three sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module linear_interp_resampler_unit_test;
	import lirs_pkg::*;

	localparam logic [POS_BITS-1:0] ONE_POS = POS_BITS'(1) << FRAC_BITS;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] smp;
		logic                   run_end;
		logic                   stream_end;
	} resampled_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [RATIO_BITS-1:0]         cfg_wr_data;
	logic                          in_valid;
	logic                          in_stall;
	logic signed [SAMPLE_BITS-1:0] in_sample;
	logic                          in_last;
	logic                          out_valid;
	logic                          out_stall;
	logic signed [SAMPLE_BITS-1:0] out_sample;
	logic                          run_last;
	logic                          stream_last;

	// predictor state
	logic [RATIO_BITS-1:0]  ratio_setting;
	logic [SAMPLE_BITS-1:0] prev_sample;
	logic [POS_BITS-1:0]    out_pos;
	logic                   have_prev;

	resampled_t pending_outputs [$];
	resampled_t want;
	int         mismatches;
	int         send_idle_pct;
	int         recv_stall_pct;

	linear_interp_resampler_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_sample   (in_sample),
		.in_last     (in_last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_sample  (out_sample),
		.run_last    (run_last),
		.stream_last (stream_last)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic logic [SAMPLE_BITS-1:0] lerp(input logic [SAMPLE_BITS-1:0] a,
			input logic [SAMPLE_BITS-1:0] b, input logic [FRAC_BITS-1:0] frac);
		longint prod;
		longint q;
		prod = longint'(frac) * (longint'($signed(b)) - longint'($signed(a))) + 32768;
		q = (prod >>> FRAC_BITS) + longint'($signed(a));
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q[SAMPLE_BITS-1:0];
	endfunction

	task automatic predict_resample(input logic [SAMPLE_BITS-1:0] cur, input logic lst);
		resampled_t            run_buf [32];
		int                    n;
		logic [RATIO_BITS-1:0] step;
		n = 0;
		step = (ratio_setting < MIN_RATIO) ? MIN_RATIO : ratio_setting;
		if (have_prev) begin
			while (out_pos < ONE_POS && n < 32) begin
				run_buf[n].smp = lerp(prev_sample, cur, out_pos[FRAC_BITS-1:0]);
				run_buf[n].run_end = 1'b0;
				run_buf[n].stream_end = 1'b0;
				n++;
				out_pos = out_pos + POS_BITS'(step);
			end
			out_pos = out_pos - ONE_POS;
		end else begin
			have_prev = 1'b1;
		end
		if (lst) begin
			while (out_pos < ONE_POS && n < 32) begin
				run_buf[n].smp = cur;
				run_buf[n].run_end = 1'b0;
				run_buf[n].stream_end = 1'b0;
				n++;
				out_pos = out_pos + POS_BITS'(step);
			end
			if (n > 0)
				run_buf[n-1].stream_end = 1'b1;
			prev_sample = '0;
			out_pos = '0;
			have_prev = 1'b0;
		end else begin
			prev_sample = cur;
		end
		if (n > 0)
			run_buf[n-1].run_end = 1'b1;
		for (int i = 0; i < n; i++)
			pending_outputs.push_back(run_buf[i]);
	endtask

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		mismatches++;
		$display("%0t ns: %s got %0d, expected %0d", $time, what, got, exp_val);
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_outputs.size() == 0) begin
				report_mismatch("unexpected output, sample", int'(out_sample), 0);
			end else begin
				want = pending_outputs.pop_front();
				if (out_sample !== want.smp)
					report_mismatch("out_sample", int'(out_sample), int'($signed(want.smp)));
				if (run_last !== want.run_end)
					report_mismatch("run_last", int'(run_last), int'(want.run_end));
				if (stream_last !== want.stream_end)
					report_mismatch("stream_last", int'(stream_last), int'(want.stream_end));
			end
		end
	end

	task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		in_sample <= smp;
		in_last   <= lst;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		predict_resample(smp, lst);
	endtask

	task automatic pause_until_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_outputs.size() != 0);
	endtask

	// inputs with no output may still sit in the command queue
	task automatic write_ratio(input logic [RATIO_BITS-1:0] value);
		pause_until_drained();
		repeat (40) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		ratio_setting = value;
	endtask

	function automatic logic [RATIO_BITS-1:0] pick_ratio();
		case ($urandom_range(9))
			0: return RATIO_BITS'($urandom_range(int'(MIN_RATIO) - 1));
			1: return RATIO_BITS'($urandom);
			2: return '1;
			default: return RATIO_BITS'($urandom_range(int'(MIN_RATIO), 24'h40000));
		endcase
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] next_sample(input logic [SAMPLE_BITS-1:0] prev);
		case ($urandom_range(3))
			0: return SAMPLE_BITS'($urandom);
			1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
			default: return prev + SAMPLE_BITS'($urandom_range(511) - 256);
		endcase
	endfunction

	task automatic test_unity_extremes();
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h8000, 1'b0);
		pause_until_drained();
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h0000, 1'b0);
		send_sample(16'h0001, 1'b0);
		send_sample(16'hFFFF, 1'b1);
	endtask

	// ratios under 1/16 are clamped, giving 32 outputs on a final step
	task automatic test_ratio_floor();
		write_ratio('0);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h7FFF, 1'b1);
		write_ratio(MIN_RATIO - 1);
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h8000, 1'b0);
		send_sample(16'd12345, 1'b1);
	endtask

	task automatic test_short_streams();
		write_ratio(24'h018000);
		send_sample(-16'sd7, 1'b1);
		send_sample(16'd100, 1'b0);
		send_sample(-16'sd100, 1'b1);
	endtask

	// final step lands between output positions: nothing, no stream_last
	task automatic test_empty_final_step();
		write_ratio('1);
		send_sample(16'd300, 1'b0);
		send_sample(-16'sd300, 1'b0);
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h8000, 1'b1);
	endtask

	task automatic test_random_streams();
		int                     left;
		int                     len;
		logic [SAMPLE_BITS-1:0] smp;
		smp = '0;
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct  = 37;
					recv_stall_pct = 45;
				end
				1: begin
					send_idle_pct  = 45;
					recv_stall_pct = 37;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			left = 67;
			while (left > 0) begin
				write_ratio(pick_ratio());
				len = $urandom_range(1, 12);
				if (len > left)
					len = left;
				for (int i = 0; i < len; i++) begin
					if (i > 0 && i == len / 2 && $urandom_range(3) == 0)
						pause_until_drained();
					smp = next_sample(smp);
					send_sample(smp, i == len - 1);
				end
				left -= len;
			end
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		in_valid    <= 1'b0;
		in_sample   <= '0;
		in_last     <= 1'b0;
		mismatches     = 0;
		send_idle_pct  = 37;
		recv_stall_pct = 45;
		ratio_setting  = RATIO_RESET;
		prev_sample    = '0;
		out_pos        = '0;
		have_prev      = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unity_extremes();
		test_ratio_floor();
		test_short_streams();
		test_empty_final_step();
		test_random_streams();

		pause_until_drained();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("linear_interp_resampler_unit: match");
		else
			$display("linear_interp_resampler_unit: mismatch");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("linear_interp_resampler_unit: mismatch");
		$finish;
	end

endmodule
